FILE: rtl/core/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
// Used by the rounding unit and the top level; no dependencies.
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ALIGN_BYTES_DEF  = 8;

    localparam int OFF_W  = 20;
    localparam int SIZE_W = 21;
    localparam int REQ_W  = 21;
    localparam int N_W    = 22;
    localparam int ST_W   = 3;

    localparam logic [SIZE_W-1:0] POOL_LIMIT = SIZE_W'(1048576);
    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(65536);

    // Result codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTALLOC = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    // One table entry: segment offset and length
    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] bytes;
    } t_seg;

    localparam int SEG_W = OFF_W + SIZE_W;

endpackage

FILE: rtl/core/ffsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffsa_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ffsa_round.sv
// Rounds a request up to a multiple of the alignment with a reciprocal multiply
// in three register stages. Depends on ffsa_pkg.
module ffsa_round #(
    parameter int P_ALIGN = ffsa_pkg::ALIGN_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ffsa_pkg::REQ_W-1:0] i_req,
    output logic                      o_done,
    output logic [ffsa_pkg::N_W-1:0]  o_n
);
    import ffsa_pkg::*;

    // floor(x / P_ALIGN) == (x * RECIP) >> SH for every x below 2**N_W, P_ALIGN up to 64
    localparam int SH = N_W + 6;
    localparam int MW = SH + 1;
    localparam int PW = N_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(P_ALIGN) - 64'd1) / 64'(P_ALIGN));
    localparam logic [N_W-1:0] PAD     = N_W'(P_ALIGN - 1);
    localparam logic [N_W-1:0] ALIGN_N = N_W'(P_ALIGN);

    logic           r_v1, r_v2, r_done;
    logic [N_W-1:0] r_x, r_q, r_n;
    logic [PW-1:0]  prod;

    assign prod = PW'(r_x) * PW'(RECIP);

    // Advance the request through pad, quotient and scale-back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
        if (i_start) begin
            r_x <= {1'b0, i_req} + PAD;
        end
        if (r_v1) begin
            r_q <= prod[SH +: N_W];
        end
        if (r_v2) begin
            r_n <= r_q * ALIGN_N;
        end
    end

    assign o_n    = r_n;
    assign o_done = r_done;

endmodule

FILE: rtl/core/first_fit_segment_allocator_unit.sv
// First-fit segment allocator: the free and used segment tables live in two
// RAMs that are scanned one entry per cycle through their registered read port.
// Depends on ffsa_pkg, ffsa_ram and ffsa_round.
//
// Takes one request at a time. An allocate rounds the size (a reciprocal
// multiply in three register stages), then scans the free table, does one
// update step and, on an exact fit, closes the gap in the free table. A free
// scans the used table from the newest entry, closes the gap in it, scans the
// free table for the insertion point and shifts the tail up, each pass one
// entry per cycle. The one RAM read port per table sets this pace. After reset
// and after each pool_size write the block writes the initial free segment
// before it takes a request. A finished result waits in the output register
// while the next request is taken.
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ALIGN_BYTES  = ffsa_pkg::ALIGN_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ffsa_pkg::SIZE_W-1:0] i_cfg_wdata,      // pool_size
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [47:0]                i_s_axis_tdata,   // request_bytes, release_offset
    input  logic                       i_s_axis_tuser,   // kind
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [47:0]                o_m_axis_tdata    // status, granted_offset, granted_bytes
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ROUND = 9'b000000010,
        S_FSCAN = 9'b000000100,
        S_AUPD  = 9'b000001000,
        S_DEL   = 9'b000010000,
        S_USCAN = 9'b000100000,
        S_JSCAN = 9'b001000000,
        S_INS   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [OFF_W-1:0]  r_rel, n_rel;
    logic [N_W-1:0]    r_n, n_n;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic [IW-1:0]     r_pos, n_pos;
    t_seg              r_seg, n_seg;
    logic [CW-1:0]     r_src, n_src;
    logic [IW-1:0]     r_dst, n_dst;
    logic              r_tsel, n_tsel;   // table under shift: 1 used, 0 free
    logic [CW-1:0]     r_free_cnt, n_free_cnt;
    logic [CW-1:0]     r_used_cnt, n_used_cnt;
    logic [SIZE_W-1:0] r_pool;
    logic              r_init, n_init;
    t_status           r_st, n_st;
    logic [OFF_W-1:0]  r_roff, n_roff;
    logic [SIZE_W-1:0] r_rbytes, n_rbytes;
    logic              r_ovalid, n_ovalid;
    t_status           r_o_st, n_o_st;
    logic [OFF_W-1:0]  r_o_off, n_o_off;
    logic [SIZE_W-1:0] r_o_bytes, n_o_bytes;

    logic              free_we, used_we;
    logic [IW-1:0]     free_waddr, used_waddr, free_raddr, used_raddr;
    t_seg              free_wdata, used_wdata, free_rd, used_rd;
    logic              round_start, round_done;
    logic [N_W-1:0]    round_n;
    logic [SIZE_W-1:0] pool_sat;
    logic [CW-1:0]     idx_m1, src_m1, shift_cnt;

    ffsa_ram #(.P_WIDTH(SEG_W), .P_DEPTH(MAX_SEGMENTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_raddr (free_raddr),
        .o_rdata (free_rd)
    );

    ffsa_ram #(.P_WIDTH(SEG_W), .P_DEPTH(MAX_SEGMENTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (used_raddr),
        .o_rdata (used_rd)
    );

    ffsa_round #(.P_ALIGN(ALIGN_BYTES)) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (round_start),
        .i_req   (r_req),
        .o_done  (round_done),
        .o_n     (round_n)
    );

    assign pool_sat  = (r_pool > POOL_LIMIT) ? POOL_LIMIT : r_pool;
    assign idx_m1    = r_idx - 1'b1;
    assign src_m1    = r_src - 1'b1;
    assign shift_cnt = r_tsel ? r_used_cnt : r_free_cnt;

    // Sequencer: scans, gap closing and tail shifts, one entry per cycle
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_rel      = r_rel;
        n_n        = r_n;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_pos      = r_pos;
        n_seg      = r_seg;
        n_src      = r_src;
        n_dst      = r_dst;
        n_tsel     = r_tsel;
        n_free_cnt = r_free_cnt;
        n_used_cnt = r_used_cnt;
        n_init     = r_init;
        n_st       = r_st;
        n_roff     = r_roff;
        n_rbytes   = r_rbytes;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_o_st     = r_o_st;
        n_o_off    = r_o_off;
        n_o_bytes  = r_o_bytes;
        free_we    = 1'b0;
        free_waddr = '0;
        free_wdata = '0;
        free_raddr = r_idx[IW-1:0];
        used_we    = 1'b0;
        used_waddr = '0;
        used_wdata = '0;
        used_raddr = idx_m1[IW-1:0];
        round_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (r_init) begin
                    // lay down the single free segment of the pool
                    free_we    = 1'b1;
                    free_wdata = '{off: '0, bytes: pool_sat};
                    n_init     = 1'b0;
                end else if (i_s_axis_tvalid) begin
                    n_req  = i_s_axis_tdata[20:0];
                    n_rel  = i_s_axis_tdata[40:21];
                    n_pend = 1'b0;
                    n_st   = ST_OK;
                    n_roff = '0;
                    n_rbytes = '0;
                    if (i_s_axis_tuser) begin
                        n_idx   = r_used_cnt;
                        n_state = S_USCAN;
                    end else if (i_s_axis_tdata[20:0] == '0) begin
                        n_st    = ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                if (!round_done && r_pend == 1'b0 && r_idx != '1) begin
                    round_start = 1'b1;
                    n_idx = '1;
                end
                if (round_done) begin
                    n_n     = round_n;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_FSCAN;
                end
            end
            S_FSCAN: begin
                // first entry large enough
                if (r_pend && ({1'b0, free_rd.bytes} >= r_n)) begin
                    n_seg = free_rd;
                    n_pos = r_pidx;
                    if (r_used_cnt == MAX_CNT) begin
                        n_st    = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_AUPD;
                    end
                end else if (r_idx >= r_free_cnt) begin
                    n_st    = ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_AUPD: begin
                used_we    = 1'b1;
                used_waddr = r_used_cnt[IW-1:0];
                used_wdata = '{off: r_seg.off, bytes: r_n[SIZE_W-1:0]};
                n_used_cnt = r_used_cnt + 1'b1;
                n_roff     = r_seg.off;
                n_rbytes   = r_n[SIZE_W-1:0];
                if ({1'b0, r_seg.bytes} == r_n) begin
                    // exact fit: close the gap in the free table
                    n_tsel  = 1'b0;
                    n_src   = CW'(r_pos) + 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_DEL;
                end else begin
                    free_we    = 1'b1;
                    free_waddr = r_pos;
                    free_wdata = '{off: r_seg.off + r_n[OFF_W-1:0],
                                   bytes: r_seg.bytes - r_n[SIZE_W-1:0]};
                    n_state    = S_DONE;
                end
            end
            S_DEL: begin
                // move each entry above the hole down by one
                if (r_pend) begin
                    if (r_tsel) begin
                        used_we    = 1'b1;
                        used_waddr = r_dst;
                        used_wdata = used_rd;
                    end else begin
                        free_we    = 1'b1;
                        free_waddr = r_dst;
                        free_wdata = free_rd;
                    end
                end
                free_raddr = r_src[IW-1:0];
                used_raddr = r_src[IW-1:0];
                if (r_src < shift_cnt) begin
                    n_pend = 1'b1;
                    n_dst  = src_m1[IW-1:0];
                    n_src  = r_src + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (r_tsel) begin
                        n_used_cnt = r_used_cnt - 1'b1;
                        n_idx      = '0;
                        n_state    = S_JSCAN;
                    end else begin
                        n_free_cnt = r_free_cnt - 1'b1;
                        n_state    = S_DONE;
                    end
                end
            end
            S_USCAN: begin
                // newest matching entry first
                if (r_pend && (used_rd.off == r_rel)) begin
                    if (r_free_cnt == MAX_CNT) begin
                        n_st    = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_seg   = used_rd;
                        n_tsel  = 1'b1;
                        n_src   = CW'(r_pidx) + 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_DEL;
                    end
                end else if (r_idx == '0) begin
                    n_st    = ST_NOTALLOC;
                    n_state = S_DONE;
                end else begin
                    n_pend = 1'b1;
                    n_pidx = idx_m1[IW-1:0];
                    n_idx  = idx_m1;
                end
            end
            S_JSCAN: begin
                // insertion point: first entry at or above the offset
                if (r_pend && (free_rd.off >= r_rel)) begin
                    n_pos   = r_pidx;
                    n_src   = r_free_cnt;
                    n_pend  = 1'b0;
                    n_state = S_INS;
                end else if (r_idx >= r_free_cnt) begin
                    n_pos   = r_free_cnt[IW-1:0];
                    n_src   = r_free_cnt;
                    n_pend  = 1'b0;
                    n_state = S_INS;
                end else begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_INS: begin
                // shift the tail up by one, then drop the segment in
                free_raddr = src_m1[IW-1:0];
                if (r_pend) begin
                    free_we    = 1'b1;
                    free_waddr = r_dst;
                    free_wdata = free_rd;
                end
                if (r_src > CW'(r_pos)) begin
                    n_pend = 1'b1;
                    n_dst  = r_src[IW-1:0];
                    n_src  = src_m1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    free_we    = 1'b1;
                    free_waddr = r_pos;
                    free_wdata = '{off: r_rel, bytes: r_seg.bytes};
                    n_free_cnt = r_free_cnt + 1'b1;
                    n_roff     = r_rel;
                    n_rbytes   = r_seg.bytes;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_o_st    = r_st;
                    n_o_off   = (r_st == ST_OK) ? r_roff : '0;
                    n_o_bytes = (r_st == ST_OK) ? r_rbytes : '0;
                    n_idx     = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= 1'b0;
            r_idx      <= '0;
            r_free_cnt <= CW'(1);
            r_used_cnt <= '0;
            r_pool     <= POOL_RESET;
            r_init     <= 1'b1;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            // a pool_size write restarts both tables
            if (i_cfg_we) begin
                r_pool     <= i_cfg_wdata;
                r_free_cnt <= CW'(1);
                r_used_cnt <= '0;
                r_init     <= 1'b1;
            end else begin
                r_free_cnt <= n_free_cnt;
                r_used_cnt <= n_used_cnt;
                r_init     <= n_init;
            end
        end
        r_req     <= n_req;
        r_rel     <= n_rel;
        r_n       <= n_n;
        r_pidx    <= n_pidx;
        r_pos     <= n_pos;
        r_seg     <= n_seg;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_tsel    <= n_tsel;
        r_st      <= n_st;
        r_roff    <= n_roff;
        r_rbytes  <= n_rbytes;
        r_o_st    <= n_o_st;
        r_o_off   <= n_o_off;
        r_o_bytes <= n_o_bytes;
    end

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_init;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {4'b0, r_o_bytes, r_o_off, r_o_st};

    // Table fill never passes the table depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_cnt <= MAX_CNT) && (r_used_cnt <= MAX_CNT))
        else $error("segment count beyond table depth");

    // A pool_size write leaves one free segment and no used segment
    a_cfg_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_free_cnt == CW'(1)) && (r_used_cnt == '0) && r_init)
        else $error("tables not restarted after pool_size write");

    // A granted segment is never empty
    a_ok_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_o_st == ST_OK)) |-> (r_o_bytes != '0))
        else $error("ok result with zero bytes");

endmodule
